@@ hdl/tcce_pkg.sv @@
// ============================================================================
// tcce_pkg
// Shared types, byte codes and sizes of the text console cursor engine.
// ============================================================================
`default_nettype none

package tcce_pkg;

    // escape sequence limits
    localparam int MAX_DIGITS = 3;
    localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int REP_W      = $clog2(MAX_DIGITS + 3);

    // cursor and move count widths
    localparam int CUR_W  = 9;
    localparam int MOVE_W = 10;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration port
    localparam int          CFG_IDX_W     = 2;
    localparam logic [1:0]  CFG_COLUMNS   = 2'd0;
    localparam logic [1:0]  CFG_ROWS      = 2'd1;
    localparam logic [1:0]  CFG_AUTO_WRAP = 2'd2;
    localparam logic [7:0]  RST_COLUMNS   = 8'd40;
    localparam logic [7:0]  RST_ROWS      = 8'd30;
    localparam logic        RST_AUTO_WRAP = 1'b1;

    // byte codes
    localparam logic [7:0] C_ESC       = 8'h1B;
    localparam logic [7:0] C_LBR       = 8'h5B;
    localparam logic [7:0] C_K         = 8'h4B;
    localparam logic [7:0] C_D         = 8'h44;
    localparam logic [7:0] C_NL        = 8'h0A;
    localparam logic [7:0] C_CR        = 8'h0D;
    localparam logic [7:0] C_BS        = 8'h08;
    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_TILDE     = 8'd126;
    localparam logic [7:0] C_ZERO      = 8'h30;
    localparam logic [7:0] C_NINE      = 8'h39;
    localparam logic [7:0] C_FONT_BASE = 8'd31;

    // result operations
    localparam logic [1:0] OP_FONT     = 2'd0;
    localparam logic [1:0] OP_HEX      = 2'd1;
    localparam logic [1:0] OP_ROW      = 2'd2;
    localparam logic [1:0] OP_ROW_FROM = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       str_end;
        logic       is_esc;
        logic       is_lbr;
        logic       is_k;
        logic       is_d;
        logic       is_digit;
        logic [3:0] digit;
        logic       quiet;
    } t_item;

    typedef struct packed {
        logic [7:0] columns;
        logic [7:0] rows;
        logic       auto_wrap;
    } t_cfg;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] code;
        logic       last;
    } t_res;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_ESC     = 4'b0010,
        PH_BRACKET = 4'b0100,
        PH_DIGITS  = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        SQ_TAKE   = 3'b001,
        SQ_REPLAY = 3'b010,
        SQ_CLEAR  = 3'b100
    } t_seq;

endpackage

`default_nettype wire

@@ hdl/tcce_front.sv @@
// ============================================================================
// tcce_front
// Input side: classifies each accepted byte for the escape parser.
// ============================================================================
`default_nettype none

module tcce_front import tcce_pkg::*; (
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_string_end,
    output logic            o_push_valid,
    input  wire logic       i_push_ready,
    output t_item           o_item
);

    logic s_is_esc;

    assign s_is_esc = (i_text_byte == C_ESC);

    assign o_push_valid = i_in_valid;
    assign o_in_ready   = i_push_ready;

    always_comb begin
        o_item.text_byte = i_text_byte;
        o_item.str_end   = i_string_end;
        o_item.is_esc    = s_is_esc;
        o_item.is_lbr    = (i_text_byte == C_LBR);
        o_item.is_k      = (i_text_byte == C_K);
        o_item.is_d      = (i_text_byte == C_D);
        o_item.is_digit  = (i_text_byte >= C_ZERO) && (i_text_byte <= C_NINE);
        o_item.digit     = 4'(i_text_byte - C_ZERO);
        // bytes that give no result when handled as a fresh byte
        o_item.quiet     = (s_is_esc && !i_string_end) || (i_text_byte == C_CR)
                           || (i_text_byte == C_BS);
    end

endmodule

`default_nettype wire

@@ hdl/tcce_fifo.sv @@
// ============================================================================
// tcce_fifo
// Short queue of classified bytes between the front and the back.
// ============================================================================
`default_nettype none

module tcce_fifo import tcce_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_item i_push_data,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready,
    output t_item      o_pop_data
);

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_AW:0]     r_cnt;
    logic              s_push;
    logic              s_pop;

    assign o_push_ready = (r_cnt != (Q_AW + 1)'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign s_push       = i_push_valid && o_push_ready;
    assign s_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (s_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            if (s_push && !s_pop) begin
                r_cnt <= r_cnt + (Q_AW + 1)'(1);
            end else if (s_pop && !s_push) begin
                r_cnt <= r_cnt - (Q_AW + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/tcce_back.sv @@
// ============================================================================
// tcce_back
// Escape parser, cursor and result sequencer; one result per cycle while the result side is ready.
// ============================================================================
`default_nettype none

module tcce_back import tcce_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_head_valid,
    input  wire t_item i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_res       o_out
);

    t_seq               r_seq, n_seq;
    t_phase             r_phase, n_phase;
    logic [CUR_W-1:0]   r_col, n_col;
    logic [CUR_W-1:0]   r_row, n_row;
    logic [MOVE_W-1:0]  r_move, n_move;
    logic [3:0]         r_dig [MAX_DIGITS];
    logic [3:0]         n_dig [MAX_DIGITS];
    logic [DCNT_W-1:0]  r_dcnt, n_dcnt;
    logic [REP_W-1:0]   r_rep_idx, n_rep_idx;
    logic [REP_W-1:0]   r_rep_len, n_rep_len;
    logic               r_clr_more, n_clr_more;
    logic               r_ov;
    t_res               r_out;

    logic               s_adv;
    logic               s_emit;
    logic               s_fail;
    t_res               s_res;
    logic [CUR_W-1:0]   s_cols;
    logic [CUR_W-1:0]   s_rows;
    logic               s_blocked;
    logic [CUR_W:0]     s_row_inc;
    logic [CUR_W-1:0]   s_row_dn;
    logic [CUR_W:0]     s_col_inc;
    logic               s_col_wrap;
    logic [MOVE_W-1:0]  s_ml_raw;
    logic [MOVE_W-1:0]  s_ml_n;
    logic               s_ml_under;
    logic [CUR_W-1:0]   s_ml_col;
    logic [CUR_W-1:0]   s_ml_row;
    logic [3:0]         s_rep_dig;
    logic [7:0]         s_rep_byte;
    logic               s_rep_busy;
    logic [REP_W-1:0]   s_rep_next;
    logic [7:0]         s_pb;
    logic               s_p_emit;
    logic               s_p_clear;
    logic [CUR_W-1:0]   s_p_col;
    logic [CUR_W-1:0]   s_p_row;
    t_res               s_p_res;
    logic               s_after_blocked;

    assign s_adv      = !r_ov || i_out_ready;
    assign s_cols     = CUR_W'(i_cfg.columns);
    assign s_rows     = CUR_W'(i_cfg.rows);
    assign s_blocked  = !i_cfg.auto_wrap && ((r_col >= s_cols) || (r_row >= s_rows));

    // row down with wrap to the top
    assign s_row_inc  = (CUR_W + 1)'(r_row) + (CUR_W + 1)'(1);
    assign s_row_dn   = (s_row_inc >= (CUR_W + 1)'(s_rows)) ? '0 : s_row_inc[CUR_W-1:0];
    assign s_col_inc  = (CUR_W + 1)'(r_col) + (CUR_W + 1)'(1);
    assign s_col_wrap = i_cfg.auto_wrap && (s_col_inc >= (CUR_W + 1)'(s_cols));

    // move left: count from the sequence in digit phase, one cell otherwise
    assign s_ml_raw   = (r_phase == PH_DIGITS) ? r_move : MOVE_W'(1);
    assign s_ml_n     = (s_ml_raw == '0) ? MOVE_W'(1) : s_ml_raw;
    assign s_ml_under = s_ml_n > MOVE_W'(r_col);
    assign s_ml_col   = s_ml_under ? s_cols : (r_col - s_ml_n[CUR_W-1:0]);
    assign s_ml_row   = !s_ml_under ? r_row :
                        ((r_row == '0) ? s_rows : (r_row - CUR_W'(1)));

    // replayed bytes of a broken sequence
    always_comb begin
        s_rep_dig = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_rep_idx == REP_W'(i + 2)) begin
                s_rep_dig = r_dig[i];
            end
        end
        if (r_rep_idx == REP_W'(0)) begin
            s_rep_byte = C_ESC;
        end else if (r_rep_idx == REP_W'(1)) begin
            s_rep_byte = C_LBR;
        end else begin
            s_rep_byte = C_ZERO + 8'(s_rep_dig);
        end
    end

    assign s_rep_busy = (r_seq == SQ_REPLAY) && (r_rep_idx != r_rep_len);
    assign s_rep_next = r_rep_idx + REP_W'(1);
    assign s_pb       = s_rep_busy ? s_rep_byte : i_head.text_byte;

    // plain byte engine
    always_comb begin
        s_p_emit       = 1'b0;
        s_p_clear      = 1'b0;
        s_p_col        = r_col;
        s_p_row        = r_row;
        s_p_res.op     = OP_FONT;
        s_p_res.column = r_col[7:0];
        s_p_res.row    = r_row[7:0];
        s_p_res.code   = '0;
        s_p_res.last   = 1'b0;
        if (!s_blocked) begin
            if (s_pb == C_NL) begin
                s_p_emit       = 1'b1;
                s_p_row        = s_row_dn;
                s_p_res.op     = OP_ROW;
                s_p_res.column = '0;
                s_p_res.row    = s_row_dn[7:0];
            end else if (s_pb == C_CR) begin
                s_p_col = '0;
            end else if (s_pb == C_BS) begin
                s_p_col = s_ml_col;
                s_p_row = s_ml_row;
            end else begin
                s_p_emit = 1'b1;
                if ((s_pb >= C_SPACE) && (s_pb <= C_TILDE)) begin
                    s_p_res.op   = OP_FONT;
                    s_p_res.code = s_pb - C_FONT_BASE;
                end else begin
                    s_p_res.op   = OP_HEX;
                    s_p_res.code = s_pb;
                end
                if (s_col_wrap) begin
                    s_p_col   = '0;
                    s_p_row   = s_row_dn;
                    s_p_clear = 1'b1;
                end else begin
                    s_p_col = s_col_inc[CUR_W-1:0];
                end
            end
        end
    end

    assign s_after_blocked = !i_cfg.auto_wrap && ((s_p_col >= s_cols) || (s_p_row >= s_rows));

    always_comb begin
        n_seq      = r_seq;
        n_phase    = r_phase;
        n_col      = r_col;
        n_row      = r_row;
        n_move     = r_move;
        n_dig      = r_dig;
        n_dcnt     = r_dcnt;
        n_rep_idx  = r_rep_idx;
        n_rep_len  = r_rep_len;
        n_clr_more = r_clr_more;
        o_pop      = 1'b0;
        s_emit     = 1'b0;
        s_fail     = 1'b0;
        s_res      = s_p_res;

        unique case (r_seq)
            SQ_TAKE: begin
                if (i_head_valid && s_adv) begin
                    if (s_blocked) begin
                        n_phase = PH_IDLE;
                        n_dcnt  = '0;
                        n_move  = '0;
                        o_pop   = 1'b1;
                    end else begin
                        unique case (r_phase)
                            PH_ESC: begin
                                if (i_head.is_lbr && !i_head.str_end) begin
                                    n_phase = PH_BRACKET;
                                    o_pop   = 1'b1;
                                end else begin
                                    s_fail = 1'b1;
                                end
                            end
                            PH_BRACKET: begin
                                if (i_head.is_k) begin
                                    n_phase      = PH_IDLE;
                                    s_emit       = 1'b1;
                                    s_res.op     = OP_ROW_FROM;
                                    s_res.column = r_col[7:0];
                                    s_res.row    = r_row[7:0];
                                    s_res.code   = '0;
                                    s_res.last   = 1'b1;
                                    o_pop        = 1'b1;
                                end else if (i_head.is_digit && !i_head.str_end) begin
                                    n_dig[0] = i_head.digit;
                                    n_dcnt   = DCNT_W'(1);
                                    n_move   = MOVE_W'(i_head.digit);
                                    n_phase  = PH_DIGITS;
                                    o_pop    = 1'b1;
                                end else begin
                                    s_fail = 1'b1;
                                end
                            end
                            PH_DIGITS: begin
                                if (i_head.is_d) begin
                                    n_phase = PH_IDLE;
                                    n_col   = s_ml_col;
                                    n_row   = s_ml_row;
                                    n_dcnt  = '0;
                                    n_move  = '0;
                                    o_pop   = 1'b1;
                                end else if (i_head.is_digit && !i_head.str_end
                                             && (r_dcnt < DCNT_W'(MAX_DIGITS))) begin
                                    for (int i = 0; i < MAX_DIGITS; i++) begin
                                        if (r_dcnt == DCNT_W'(i)) begin
                                            n_dig[i] = i_head.digit;
                                        end
                                    end
                                    n_dcnt = r_dcnt + DCNT_W'(1);
                                    n_move = (r_move << 3) + (r_move << 1)
                                             + MOVE_W'(i_head.digit);
                                    o_pop  = 1'b1;
                                end else begin
                                    s_fail = 1'b1;
                                end
                            end
                            PH_IDLE: begin
                                if (i_head.is_esc && !i_head.str_end) begin
                                    n_phase = PH_ESC;
                                    o_pop   = 1'b1;
                                end else begin
                                    n_col      = s_p_col;
                                    n_row      = s_p_row;
                                    s_emit     = s_p_emit;
                                    s_res.last = !s_p_clear;
                                    if (s_p_clear) begin
                                        n_seq      = SQ_CLEAR;
                                        n_clr_more = 1'b0;
                                    end else begin
                                        o_pop = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                        if (s_fail) begin
                            n_rep_len = REP_W'(1) + REP_W'(r_phase != PH_ESC)
                                        + ((r_phase == PH_DIGITS) ? REP_W'(r_dcnt) : '0);
                            n_rep_idx = '0;
                            n_phase   = PH_IDLE;
                            n_dcnt    = '0;
                            n_move    = '0;
                            n_seq     = SQ_REPLAY;
                        end
                    end
                end
            end
            SQ_REPLAY: begin
                if (s_adv) begin
                    if (s_rep_busy) begin
                        n_col      = s_p_col;
                        n_row      = s_p_row;
                        s_emit     = s_p_emit;
                        s_res.last = !s_p_clear && (s_after_blocked
                                     || ((s_rep_next == r_rep_len) && i_head.quiet));
                        n_rep_idx  = s_rep_next;
                        if (s_p_clear) begin
                            n_seq      = SQ_CLEAR;
                            n_clr_more = 1'b1;
                        end
                    end else if (!s_blocked && i_head.is_esc && !i_head.str_end) begin
                        n_phase = PH_ESC;
                        o_pop   = 1'b1;
                        n_seq   = SQ_TAKE;
                    end else begin
                        n_col      = s_p_col;
                        n_row      = s_p_row;
                        s_emit     = s_p_emit;
                        s_res.last = !s_p_clear;
                        if (s_p_clear) begin
                            n_seq      = SQ_CLEAR;
                            n_clr_more = 1'b0;
                        end else begin
                            o_pop = 1'b1;
                            n_seq = SQ_TAKE;
                        end
                    end
                end
            end
            SQ_CLEAR: begin
                if (s_adv) begin
                    s_emit       = 1'b1;
                    s_res.op     = OP_ROW;
                    s_res.column = '0;
                    s_res.row    = r_row[7:0];
                    s_res.code   = '0;
                    s_res.last   = !r_clr_more || ((r_rep_idx == r_rep_len) && i_head.quiet);
                    if (r_clr_more) begin
                        n_seq = SQ_REPLAY;
                    end else begin
                        o_pop = 1'b1;
                        n_seq = SQ_TAKE;
                    end
                end
            end
            default: begin
                n_seq = SQ_TAKE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= SQ_TAKE;
            r_phase    <= PH_IDLE;
            r_col      <= '0;
            r_row      <= '0;
            r_move     <= '0;
            r_dcnt     <= '0;
            r_rep_idx  <= '0;
            r_rep_len  <= '0;
            r_clr_more <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_phase    <= n_phase;
            r_col      <= n_col;
            r_row      <= n_row;
            r_move     <= n_move;
            r_dcnt     <= n_dcnt;
            r_rep_idx  <= n_rep_idx;
            r_rep_len  <= n_rep_len;
            r_clr_more <= n_clr_more;
            if (s_adv) begin
                r_ov <= s_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig <= n_dig;
        if (s_adv && s_emit) begin
            r_out <= s_res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    a_clear_needs_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_CLEAR) |-> i_cfg.auto_wrap)
        else $error("row clear pending without auto wrap");

    a_dcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt <= DCNT_W'(MAX_DIGITS))
        else $error("held digit count beyond limit");

    a_replay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep_idx <= r_rep_len)
        else $error("replay index past replay length");

    a_open_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.last) |-> (r_seq != SQ_TAKE))
        else $error("non-final result held while no item is in progress");

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_head_valid && s_adv))
        else $error("queue popped without a head item or output space");

endmodule

`default_nettype wire

@@ hdl/text_console_cursor_engine.sv @@
// ============================================================================
// text_console_cursor_engine
// Text byte stream to glyph, hex and row clear commands, with cursor and escapes.
// ============================================================================
// Path: with the queue empty and the result side ready, an accepted byte is queued
// and its first result is registered in the back, after the replay state for a byte
// that breaks an escape. Throughput: one byte per cycle while each byte gives at most
// one result and the result side is ready; a byte stays at the queue head while its
// row clear, or the replays and row clears of the sequence it breaks, go out.
// Reset: synchronous; cursor home, parser idle, 40 columns, 30 rows, wrap on.
`default_nettype none

module text_console_cursor_engine import tcce_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_text_byte,
    input  wire logic                 i_string_end,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_op,
    output logic [7:0]                o_cell_column,
    output logic [7:0]                o_cell_row,
    output logic [7:0]                o_code,
    output logic                      o_last,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    t_cfg  r_cfg;
    t_item s_push_item;
    logic  s_push_valid;
    logic  s_push_ready;
    logic  s_head_valid;
    t_item s_head;
    logic  s_pop;
    t_res  s_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns   <= RST_COLUMNS;
            r_cfg.rows      <= RST_ROWS;
            r_cfg.auto_wrap <= RST_AUTO_WRAP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COLUMNS:   r_cfg.columns   <= i_cfg_data;
                CFG_ROWS:      r_cfg.rows      <= i_cfg_data;
                CFG_AUTO_WRAP: r_cfg.auto_wrap <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    tcce_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_text_byte  (i_text_byte),
        .i_string_end (i_string_end),
        .o_push_valid (s_push_valid),
        .i_push_ready (s_push_ready),
        .o_item       (s_push_item)
    );

    tcce_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_push_valid),
        .o_push_ready (s_push_ready),
        .i_push_data  (s_push_item),
        .o_pop_valid  (s_head_valid),
        .i_pop_ready  (s_pop),
        .o_pop_data   (s_head)
    );

    tcce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (s_head_valid),
        .i_head       (s_head),
        .o_pop        (s_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (s_out)
    );

    assign o_op          = s_out.op;
    assign o_cell_column = s_out.column;
    assign o_cell_row    = s_out.row;
    assign o_code        = s_out.code;
    assign o_last        = s_out.last;

endmodule

`default_nettype wire

@@ verif/tcce_checker.sv @@
// ============================================================================
// tcce_checker
// Watches the byte, result and register channels of the text console cursor
// engine. Tracks cursor, escape parser and screen settings for every byte
// accepted, queues the draw and clear commands it must produce, and compares
// each result transaction against the oldest queued command.
// ============================================================================

module tcce_checker import tcce_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic [7:0]           i_text_byte,
    input  wire logic                 i_string_end,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic [1:0]           i_op,
    input  wire logic [7:0]           i_cell_column,
    input  wire logic [7:0]           i_cell_row,
    input  wire logic [7:0]           i_code,
    input  wire logic                 i_last,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    output int                        o_mismatches,
    output int                        o_pending
);

    logic [7:0]        scr_columns;
    logic [7:0]        scr_rows;
    logic              scr_wrap;

    logic [CUR_W-1:0]  cur_col;
    logic [CUR_W-1:0]  cur_row;
    t_phase            esc_phase;
    logic [MOVE_W-1:0] move_cnt;
    logic [3:0]        digits [MAX_DIGITS];
    logic [DCNT_W-1:0] digit_cnt;

    t_res              draw_cmds [$];
    t_res              byte_cmds [$];
    t_res              got;
    t_res              want;
    int                mismatch_cnt;

    function automatic logic cursor_blocked();
        return !scr_wrap && (cur_col >= scr_columns || cur_row >= scr_rows);
    endfunction

    function automatic void push_cmd(input logic [1:0] op, input logic [CUR_W-1:0] col,
                                     input logic [CUR_W-1:0] row, input logic [7:0] code);
        t_res cmd;
        if (byte_cmds.size() < 12) begin
            cmd.op     = op;
            cmd.column = col[7:0];
            cmd.row    = row[7:0];
            cmd.code   = code;
            cmd.last   = 1'b0;
            byte_cmds.push_back(cmd);
        end
    endfunction

    function automatic void next_row_clear();
        if (cur_row + 1 >= scr_rows) begin
            cur_row = '0;
        end else begin
            cur_row = cur_row + CUR_W'(1);
        end
        push_cmd(OP_ROW, '0, cur_row, 8'd0);
    endfunction

    function automatic void step_left(input int n);
        int c;
        int r;
        if (n == 0) begin
            n = 1;
        end
        c = int'(cur_col) - n;
        if (c < 0) begin
            cur_col = CUR_W'(scr_columns);
            r = int'(cur_row) - 1;
            if (r < 0) begin
                cur_row = CUR_W'(scr_rows);
            end else begin
                cur_row = CUR_W'(r);
            end
        end else begin
            cur_col = CUR_W'(c);
        end
    endfunction

    function automatic void draw_byte(input logic [7:0] b);
        if (cursor_blocked()) begin
            return;
        end
        if (b == C_NL) begin
            next_row_clear();
        end else if (b == C_CR) begin
            cur_col = '0;
        end else if (b == C_BS) begin
            step_left(1);
        end else begin
            if (b >= C_SPACE && b <= C_TILDE) begin
                push_cmd(OP_FONT, cur_col, cur_row, b - C_FONT_BASE);
            end else begin
                push_cmd(OP_HEX, cur_col, cur_row, b);
            end
            cur_col = cur_col + CUR_W'(1);
            if (cur_col >= scr_columns && scr_wrap) begin
                cur_col = '0;
                next_row_clear();
            end
        end
    endfunction

    function automatic void start_byte(input logic [7:0] b, input logic fin);
        if (cursor_blocked()) begin
            return;
        end
        if (b == C_ESC && !fin) begin
            esc_phase = PH_ESC;
        end else begin
            draw_byte(b);
        end
    endfunction

    function automatic void replay_sequence(input logic [7:0] b, input logic fin);
        t_phase was;
        int     i;
        was       = esc_phase;
        esc_phase = PH_IDLE;
        draw_byte(C_ESC);
        if (was == PH_BRACKET || was == PH_DIGITS) begin
            draw_byte(C_LBR);
        end
        if (was == PH_DIGITS) begin
            for (i = 0; i < digit_cnt; i++) begin
                draw_byte(C_ZERO + 8'(digits[i]));
            end
        end
        digit_cnt = '0;
        move_cnt  = '0;
        start_byte(b, fin);
    endfunction

    function automatic void interpret_byte(input logic [7:0] b, input logic fin);
        logic is_digit;
        is_digit = (b >= C_ZERO && b <= C_NINE);
        byte_cmds.delete();
        if (cursor_blocked()) begin
            esc_phase = PH_IDLE;
            digit_cnt = '0;
            move_cnt  = '0;
            return;
        end
        case (esc_phase)
            PH_ESC: begin
                if (b == C_LBR && !fin) begin
                    esc_phase = PH_BRACKET;
                end else begin
                    replay_sequence(b, fin);
                end
            end
            PH_BRACKET: begin
                if (b == C_K) begin
                    esc_phase = PH_IDLE;
                    push_cmd(OP_ROW_FROM, cur_col, cur_row, 8'd0);
                end else if (is_digit && !fin) begin
                    digits[0] = 4'(b - C_ZERO);
                    digit_cnt = DCNT_W'(1);
                    move_cnt  = MOVE_W'(b - C_ZERO);
                    esc_phase = PH_DIGITS;
                end else begin
                    replay_sequence(b, fin);
                end
            end
            PH_DIGITS: begin
                if (b == C_D) begin
                    esc_phase = PH_IDLE;
                    step_left(int'(move_cnt));
                    digit_cnt = '0;
                    move_cnt  = '0;
                end else if (is_digit && !fin && digit_cnt < MAX_DIGITS) begin
                    digits[digit_cnt] = 4'(b - C_ZERO);
                    digit_cnt = digit_cnt + DCNT_W'(1);
                    move_cnt  = MOVE_W'(int'(move_cnt) * 10 + int'(b - C_ZERO));
                end else begin
                    replay_sequence(b, fin);
                end
            end
            default: begin
                esc_phase = PH_IDLE;
                start_byte(b, fin);
            end
        endcase
        if (byte_cmds.size() > 0) begin
            byte_cmds[byte_cmds.size() - 1].last = 1'b1;
        end
        foreach (byte_cmds[i]) begin
            draw_cmds.push_back(byte_cmds[i]);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scr_columns  = RST_COLUMNS;
            scr_rows     = RST_ROWS;
            scr_wrap     = RST_AUTO_WRAP;
            cur_col      = '0;
            cur_row      = '0;
            esc_phase    = PH_IDLE;
            move_cnt     = '0;
            digit_cnt    = '0;
            mismatch_cnt = 0;
            draw_cmds.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COLUMNS:   scr_columns = i_cfg_data;
                    CFG_ROWS:      scr_rows    = i_cfg_data;
                    CFG_AUTO_WRAP: scr_wrap    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_op, i_cell_column, i_cell_row, i_code, i_last};
                if (draw_cmds.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: expected no result", $time);
                    $display("%0t: got op %0d column %0d row %0d code %0d last %0b",
                             $time, got.op, got.column, got.row, got.code, got.last);
                end else begin
                    want = draw_cmds.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        $display("%0t: expected op %0d column %0d row %0d code %0d last %0b",
                                 $time, want.op, want.column, want.row, want.code, want.last);
                        $display("%0t:      got op %0d column %0d row %0d code %0d last %0b",
                                 $time, got.op, got.column, got.row, got.code, got.last);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                interpret_byte(i_text_byte, i_string_end);
            end
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= draw_cmds.size();
    end

endmodule

@@ verif/tb.sv @@
// ============================================================================
// tb
// Drives text bytes and screen settings into the text console cursor engine:
// directed bytes and escapes first, then phases of random text, controls and
// well-formed or broken escape sequences under several screen sizes, with
// bursty input and a stalling result side. The checker judges every result.
// ============================================================================

module tb;
    import tcce_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 330;
    localparam int SETTLE       = 8;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_COMB
    } t_rx_mode;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           text_byte;
    logic                 string_end;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    logic [1:0]           op;
    logic [7:0]           cell_column;
    logic [7:0]           cell_row;
    logic [7:0]           code;
    logic                 last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    int                   mismatches;
    int                   pending;
    int                   burst_left;
    int                   bytes_sent;
    t_rx_mode             rx_mode = RX_OPEN;
    int                   rx_hold = 0;

    text_console_cursor_engine i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_text_byte   (text_byte),
        .i_string_end  (string_end),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_op          (op),
        .o_cell_column (cell_column),
        .o_cell_row    (cell_row),
        .o_code        (code),
        .o_last        (last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    tcce_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_text_byte   (text_byte),
        .i_string_end  (string_end),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_op          (op),
        .i_cell_column (cell_column),
        .i_cell_row    (cell_row),
        .i_code        (code),
        .i_last        (last),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk) begin
        if (rx_hold == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_hold <= $urandom_range(20, 150);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:  out_ready <= 1'b1;
            RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
            default:  out_ready <= (rx_hold % 5 > 1);
        endcase
    end

    function automatic logic [7:0] rand_digit();
        return C_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        bytes_sent++;
        in_valid   <= 1'b1;
        text_byte  <= b;
        string_end <= fin;
        do @(posedge clk); while (!in_ready);
    endtask

    // hold input until every queued command has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // home the cursor inside the new screen before dropping auto-wrap
    task automatic configure(input logic [7:0] cols, input logic [7:0] nrows, input logic wrap);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, nrows);
        write_reg(CFG_AUTO_WRAP, 8'd1);
        cfg_valid <= 1'b0;
        if (!wrap) begin
            send_byte(C_CR, 1'b0);
            send_byte(C_NL, 1'b1);
            drain();
            write_reg(CFG_AUTO_WRAP, 8'd0);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic send_chunk();
        int         pick;
        int         n;
        int         level;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            b = 8'($urandom_range(C_SPACE, C_TILDE));
            send_byte(b, $urandom_range(0, 7) == 0);
        end else if (pick < 50) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b, 1'($urandom_range(0, 1)));
        end else if (pick < 58) begin
            case ($urandom_range(0, 2))
                0:       b = C_NL;
                1:       b = C_CR;
                default: b = C_BS;
            endcase
            send_byte(b, $urandom_range(0, 5) == 0);
        end else if (pick < 72) begin
            send_byte(C_ESC, 1'b0);
            send_byte(C_LBR, 1'b0);
            n = $urandom_range(1, MAX_DIGITS);
            repeat (n) send_byte(rand_digit(), 1'b0);
            send_byte(C_D, 1'($urandom_range(0, 1)));
        end else if (pick < 80) begin
            send_byte(C_ESC, 1'b0);
            send_byte(C_LBR, 1'b0);
            send_byte(C_K, 1'($urandom_range(0, 1)));
        end else begin
            send_byte(C_ESC, 1'b0);
            level = $urandom_range(0, 2);
            if (level >= 1) begin
                send_byte(C_LBR, 1'b0);
            end
            if (level == 2) begin
                n = $urandom_range(1, MAX_DIGITS + 1);
                repeat (n) send_byte(rand_digit(), 1'b0);
            end
            case ($urandom_range(0, 5))
                0:       b = C_ESC;
                1:       b = C_LBR;
                2:       b = rand_digit();
                3:       b = C_K;
                4:       b = C_D;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int phase;
        int stop;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        text_byte  <= 8'd0;
        string_end <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_COLUMNS;
        cfg_data   <= 8'd0;
        burst_left = 0;
        bytes_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_byte(8'h41, 1'b0);
        send_byte(C_SPACE, 1'b0);
        send_byte(C_TILDE, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(C_NL, 1'b0);
        send_byte(C_CR, 1'b0);
        send_byte(C_BS, 1'b0);
        send_byte(C_ESC, 1'b0);
        send_byte(C_LBR, 1'b0);
        send_byte(C_K, 1'b0);
        send_byte(C_ESC, 1'b0);
        send_byte(C_LBR, 1'b0);
        send_byte(C_ZERO + 8'd7, 1'b0);
        send_byte(C_D, 1'b0);
        send_byte(C_ESC, 1'b0);
        send_byte(C_LBR, 1'b0);
        send_byte(C_NINE, 1'b0);
        send_byte(C_NINE, 1'b0);
        send_byte(C_NINE, 1'b0);
        send_byte(C_NINE, 1'b0);
        send_byte(C_ESC, 1'b1);
        send_byte(C_ESC, 1'b0);
        send_byte(C_LBR, 1'b1);
        drain();

        phase = 0;
        while (bytes_sent < RANDOM_ITEMS) begin
            case (phase % 8)
                0:       configure(8'd1, 8'd1, 1'b1);
                1:       configure(8'd255, 8'd255, 1'b1);
                2:       configure(8'd3, 8'd2, 1'b0);
                3:       configure(8'd7, 8'd5, 1'b1);
                4:       configure(8'd255, 8'd255, 1'b0);
                5:       configure(8'd1, 8'd255, 1'b0);
                6:       configure(8'd255, 8'd1, 1'b1);
                default: configure(8'($urandom_range(1, 12)), 8'($urandom_range(1, 6)),
                                   1'($urandom_range(0, 1)));
            endcase
            stop = bytes_sent + $urandom_range(30, 50);
            while (bytes_sent < stop) send_chunk();
            drain();
            phase++;
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 1000000);
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/tcce_pkg.sv
hdl/tcce_front.sv
hdl/tcce_fifo.sv
hdl/tcce_back.sv
hdl/text_console_cursor_engine.sv
verif/tcce_checker.sv
verif/tb.sv
